@@ hdl/vdc_pkg.sv @@
// Shared types and constants of the ventilation door controller.
// Holds the move-mode enum, command/event/register codes and the bundles
// passed between the top level and the step core. No dependencies.
`default_nettype none

package vdc_pkg;

  // Width of the configuration write data (widest register)
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Command codes carried by each tick
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // Event codes reported with each result
  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_CLOSED        = 4'd1;
  localparam logic [3:0] EV_OPENED        = 4'd2;
  localparam logic [3:0] EV_CLOSE_TIMEOUT = 4'd3;
  localparam logic [3:0] EV_OPEN_TIMEOUT  = 4'd4;
  localparam logic [3:0] EV_STOPPED       = 4'd5;
  localparam logic [3:0] EV_AUTO_OPEN     = 4'd6;
  localparam logic [3:0] EV_AUTO_CLOSE    = 4'd7;
  localparam logic [3:0] EV_MANUAL_OPEN   = 4'd8;
  localparam logic [3:0] EV_MANUAL_CLOSE  = 4'd9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_OPEN_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CLOSE_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_TIMEOUT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_PERIOD   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_PERIOD     = 3'd6;

  // Register values after reset
  localparam logic signed [7:0] RST_TEMP_OPEN_LIMIT  = 8'sd26;
  localparam logic signed [7:0] RST_TEMP_CLOSE_LIMIT = 8'sd22;
  localparam logic [14:0]       RST_TILT_LIMIT       = 15'd16384;
  localparam logic [15:0]       RST_LOCKOUT_TICKS    = 16'd4000;
  localparam logic [15:0]       RST_MOVE_TIMEOUT     = 16'd4000;
  localparam logic [15:0]       RST_MEASURE_PERIOD   = 16'd200;
  localparam logic [15:0]       RST_CHECK_PERIOD     = 16'd20;

  // Motor drive values
  localparam logic signed [1:0] DIR_OPEN  = 2'sb01;
  localparam logic signed [1:0] DIR_STOP  = 2'sb00;
  localparam logic signed [1:0] DIR_CLOSE = 2'sb11;

  // Move mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_OPEN  = 3'b010,
    MODE_CLOSE = 3'b100
  } mode_t;

  // Configuration register bundle
  typedef struct packed {
    logic signed [7:0] temp_open_limit;
    logic signed [7:0] temp_close_limit;
    logic [14:0]       tilt_limit;
    logic [15:0]       lockout_ticks;
    logic [15:0]       move_timeout_ticks;
    logic [15:0]       measure_period_ticks;
    logic [15:0]       check_period_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic signed [1:0] motor_dir;
    logic              vent_open;
    logic [3:0]        event_code;
    logic              temp_report_valid;
    logic signed [7:0] temp_report;
    logic              console_locked;
    logic              moving;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/vdc_core.sv @@
// Controller state and the per-tick step logic of the door controller.
// Computes one result from the registered tick and updates state on step_en.
// Depends on vdc_pkg.
`default_nettype none

module vdc_core
  import vdc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step_en,
  input  wire cfg_t                    cfg,
  input  wire logic [1:0]              command,
  input  wire logic signed [15:0]      accel_y,
  input  wire logic signed [15:0]      accel_z,
  input  wire logic signed [7:0]       temperature,
  output res_t                         res
);

  // Compare width covers both the counters and the 16 bit limits
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  // State registers
  logic  want_open, want_close, want_stop;
  logic  door_pos, hot_flag, lock_flag, last_temp_valid;
  cnt_t  lock_count, move_elapsed, check_count, measure_count;
  mode_t move_mode;
  logic signed [7:0] last_temp;

  logic  want_open_next, want_close_next, want_stop_next;
  logic  door_pos_next, hot_flag_next, lock_flag_next, last_temp_valid_next;
  cnt_t  lock_count_next, move_elapsed_next, check_count_next, measure_count_next;
  mode_t move_mode_next;
  logic signed [7:0] last_temp_next;

  logic [3:0]        ev;
  logic              rep_valid;
  logic signed [7:0] rep;

  // Derived values
  logic [15:0]      check_per, measure_per;
  logic [16:0]      mag_y, mag_z;
  logic             beyond_y, beyond_z;
  logic [CMP_W-1:0] cnt_max_ext, lock_load_ext;
  cnt_t             lock_load;

  assign check_per   = (cfg.check_period_ticks == '0) ? 16'd1 : cfg.check_period_ticks;
  assign measure_per = (cfg.measure_period_ticks == '0) ? 16'd1 : cfg.measure_period_ticks;

  // End-position test: |sample| > tilt_limit
  assign mag_y = accel_y[15] ? (17'd0 - {accel_y[15], accel_y}) : {1'b0, accel_y};
  assign mag_z = accel_z[15] ? (17'd0 - {accel_z[15], accel_z}) : {1'b0, accel_z};
  assign beyond_y = mag_y > {2'b00, cfg.tilt_limit};
  assign beyond_z = mag_z > {2'b00, cfg.tilt_limit};

  // Lockout length, clipped to the counter range
  assign cnt_max_ext   = CMP_W'({COUNT_WIDTH{1'b1}});
  assign lock_load_ext = CMP_W'(cfg.lockout_ticks);
  assign lock_load     = (lock_load_ext > cnt_max_ext) ? '1 : COUNT_WIDTH'(lock_load_ext);

  // Step logic for one tick
  always_comb begin
    want_open_next       = want_open  | (command == CMD_OPEN);
    want_close_next      = want_close | (command == CMD_CLOSE);
    want_stop_next       = want_stop  | (command == CMD_STOP);
    door_pos_next        = door_pos;
    hot_flag_next        = hot_flag;
    lock_flag_next       = lock_flag;
    lock_count_next      = lock_count;
    move_mode_next       = move_mode;
    move_elapsed_next    = move_elapsed;
    check_count_next     = check_count;
    last_temp_next       = last_temp;
    last_temp_valid_next = last_temp_valid;
    ev                   = EV_NONE;
    rep_valid            = 1'b0;
    rep                  = '0;

    // lockout countdown
    if (lock_count != '0) begin
      lock_count_next = lock_count - 1'b1;
      if (lock_count_next == '0) begin
        lock_flag_next = 1'b0;
      end
    end
    measure_count_next = sat_inc(measure_count);

    unique case (move_mode)
      MODE_OPEN, MODE_CLOSE: begin
        move_elapsed_next = sat_inc(move_elapsed);
        check_count_next  = sat_inc(check_count);
        if (CMP_W'(check_count_next) >= CMP_W'(check_per)) begin
          check_count_next = '0;
          if ((move_mode == MODE_CLOSE) ? beyond_y : beyond_z) begin
            door_pos_next  = (move_mode == MODE_OPEN);
            ev             = (move_mode == MODE_OPEN) ? EV_OPENED : EV_CLOSED;
            move_mode_next = MODE_IDLE;
          end
        end
        if (move_mode_next != MODE_IDLE &&
            CMP_W'(move_elapsed_next) > CMP_W'(cfg.move_timeout_ticks)) begin
          ev             = (move_mode == MODE_OPEN) ? EV_OPEN_TIMEOUT : EV_CLOSE_TIMEOUT;
          move_mode_next = MODE_IDLE;
        end
      end
      default: begin
        move_mode_next = MODE_IDLE;
        // serve one latched command, open first
        priority if (want_open_next) begin
          want_open_next    = 1'b0;
          lock_flag_next    = 1'b1;
          lock_count_next   = lock_load;
          move_mode_next    = MODE_OPEN;
          move_elapsed_next = '0;
          check_count_next  = '0;
          ev                = EV_MANUAL_OPEN;
        end else if (want_close_next) begin
          want_close_next   = 1'b0;
          lock_flag_next    = 1'b1;
          lock_count_next   = lock_load;
          move_mode_next    = MODE_CLOSE;
          move_elapsed_next = '0;
          check_count_next  = '0;
          ev                = EV_MANUAL_CLOSE;
        end else if (want_stop_next) begin
          want_stop_next  = 1'b0;
          lock_flag_next  = 1'b1;
          lock_count_next = lock_load;
          ev              = EV_STOPPED;
        end else begin
          // nothing latched
        end

        // temperature measurement and hysteresis
        if (move_mode_next == MODE_IDLE &&
            CMP_W'(measure_count_next) >= CMP_W'(measure_per)) begin
          measure_count_next = '0;
          if (!last_temp_valid || temperature != last_temp) begin
            rep_valid            = 1'b1;
            rep                  = temperature;
            last_temp_next       = temperature;
            last_temp_valid_next = 1'b1;
          end
          if (!lock_flag_next) begin
            priority if (!hot_flag && temperature > cfg.temp_open_limit) begin
              hot_flag_next     = 1'b1;
              move_mode_next    = MODE_OPEN;
              move_elapsed_next = '0;
              check_count_next  = '0;
              ev                = EV_AUTO_OPEN;
            end else if (hot_flag && temperature < cfg.temp_close_limit) begin
              hot_flag_next     = 1'b0;
              move_mode_next    = MODE_CLOSE;
              move_elapsed_next = '0;
              check_count_next  = '0;
              ev                = EV_AUTO_CLOSE;
            end else begin
              // inside the hysteresis band
            end
          end
        end
      end
    endcase
  end

  // State update; reset starts a closing move
  always_ff @(posedge clk) begin
    if (rst) begin
      want_open       <= 1'b0;
      want_close      <= 1'b0;
      want_stop       <= 1'b0;
      door_pos        <= 1'b0;
      hot_flag        <= 1'b0;
      lock_flag       <= 1'b0;
      lock_count      <= '0;
      move_mode       <= MODE_CLOSE;
      move_elapsed    <= '0;
      check_count     <= '0;
      measure_count   <= '0;
      last_temp       <= '0;
      last_temp_valid <= 1'b0;
    end else if (step_en) begin
      want_open       <= want_open_next;
      want_close      <= want_close_next;
      want_stop       <= want_stop_next;
      door_pos        <= door_pos_next;
      hot_flag        <= hot_flag_next;
      lock_flag       <= lock_flag_next;
      lock_count      <= lock_count_next;
      move_mode       <= move_mode_next;
      move_elapsed    <= move_elapsed_next;
      check_count     <= check_count_next;
      measure_count   <= measure_count_next;
      last_temp       <= last_temp_next;
      last_temp_valid <= last_temp_valid_next;
    end
  end

  // Result of this tick
  always_comb begin
    res.motor_dir         = (move_mode_next == MODE_OPEN)  ? DIR_OPEN :
                            (move_mode_next == MODE_CLOSE) ? DIR_CLOSE : DIR_STOP;
    res.vent_open         = door_pos_next;
    res.event_code        = ev;
    res.temp_report_valid = rep_valid;
    res.temp_report       = rep;
    res.console_locked    = lock_flag_next;
    res.moving            = (move_mode_next != MODE_IDLE);
  end

endmodule

`default_nettype wire

@@ hdl/vent_door_controller.sv @@
// Top level of the ventilation door controller: tick and result channels,
// configuration registers, input and result registers around vdc_core.
// Depends on vdc_pkg and vdc_core.
//
//   channel   handshake               payload
//   tick in   in_valid / in_stall     command, accel_y, accel_z, temperature
//   result    out_valid / out_stall   motor_dir, vent_open, event_code,
//                                     temp_report_valid, temp_report,
//                                     console_locked, moving
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One tick request is taken every cycle unless in_stall is high; the input register
// holds it until its result is loaded into the result register to be taken.
// The controller state is updated in the same cycle the result is registered.
// Reset (rst, synchronous) loads the register defaults and starts a close move.
// A stalled result holds the result register and, once the input register is
// also full, in_stall rises; cfg_ready is always high.
`default_nettype none

module vent_door_controller
  import vdc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // tick requests
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             command,
  input  wire logic signed [15:0]     accel_y,
  input  wire logic signed [15:0]     accel_z,
  input  wire logic signed [7:0]      temperature,
  // results
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [1:0]           motor_dir,
  output logic                        vent_open,
  output logic [3:0]                  event_code,
  output logic                        temp_report_valid,
  output logic signed [7:0]           temp_report,
  output logic                        console_locked,
  output logic                        moving,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_open_limit      <= RST_TEMP_OPEN_LIMIT;
      cfg.temp_close_limit     <= RST_TEMP_CLOSE_LIMIT;
      cfg.tilt_limit           <= RST_TILT_LIMIT;
      cfg.lockout_ticks        <= RST_LOCKOUT_TICKS;
      cfg.move_timeout_ticks   <= RST_MOVE_TIMEOUT;
      cfg.measure_period_ticks <= RST_MEASURE_PERIOD;
      cfg.check_period_ticks   <= RST_CHECK_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_OPEN_LIMIT:  cfg.temp_open_limit      <= cfg_data[7:0];
        REG_TEMP_CLOSE_LIMIT: cfg.temp_close_limit     <= cfg_data[7:0];
        REG_TILT_LIMIT:       cfg.tilt_limit           <= cfg_data[14:0];
        REG_LOCKOUT_TICKS:    cfg.lockout_ticks        <= cfg_data;
        REG_MOVE_TIMEOUT:     cfg.move_timeout_ticks   <= cfg_data;
        REG_MEASURE_PERIOD:   cfg.measure_period_ticks <= cfg_data;
        REG_CHECK_PERIOD:     cfg.check_period_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic              s1_valid;
  logic [1:0]        s1_command;
  logic signed [15:0] s1_accel_y, s1_accel_z;
  logic signed [7:0] s1_temperature;
  logic              adv;
  res_t              step_res, out_res;

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command     <= command;
      s1_accel_y     <= accel_y;
      s1_accel_z     <= accel_z;
      s1_temperature <= temperature;
    end
  end

  // Step logic and state
  vdc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (adv),
    .cfg         (cfg),
    .command     (s1_command),
    .accel_y     (s1_accel_y),
    .accel_z     (s1_accel_z),
    .temperature (s1_temperature),
    .res         (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign motor_dir         = out_res.motor_dir;
  assign vent_open         = out_res.vent_open;
  assign event_code        = out_res.event_code;
  assign temp_report_valid = out_res.temp_report_valid;
  assign temp_report       = out_res.temp_report;
  assign console_locked    = out_res.console_locked;
  assign moving            = out_res.moving;

endmodule

`default_nettype wire

@@ hdl/vdc_checker.sv @@
// Port-level checks for the ventilation door controller, bound to the top.
// Depends on vdc_pkg and vent_door_controller.
`default_nettype none

module vdc_port_checks
  import vdc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [1:0] motor_dir,
  input wire logic              vent_open,
  input wire logic [3:0]        event_code,
  input wire logic              temp_report_valid,
  input wire logic signed [7:0] temp_report,
  input wire logic              moving
);

  // moving flag agrees with the motor drive
  a_moving_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (moving == (motor_dir != DIR_STOP)))
    else $error("moving flag disagrees with motor_dir");

  // no report, no temperature value
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !temp_report_valid |-> (temp_report == 8'sd0))
    else $error("temp_report nonzero without a report");

  // end-position events record the matching door position
  a_end_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_OPENED || event_code == EV_CLOSED)
      |-> (vent_open == (event_code == EV_OPENED)))
    else $error("door position does not match end event");

  // an opening start drives the motor open
  a_open_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_MANUAL_OPEN || event_code == EV_AUTO_OPEN)
      |-> (moving && motor_dir == DIR_OPEN))
    else $error("open start without opening drive");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(motor_dir))
    else $error("stalled result changed");

endmodule

bind vent_door_controller vdc_port_checks u_port_checks (.*);

`default_nettype wire
